/* rtl/ssc_pkg.sv */
// shared types and constants of the subset sum counter
`timescale 1ns / 1ps
package ssc_pkg;
    localparam int TARGET_W = 36;
    localparam int COUNT_W  = 33;
    localparam int ITEM_W   = 30;
    localparam int S_DATA_W = 32;
    localparam int M_DATA_W = 40;

    typedef logic alu_op_t;
    localparam alu_op_t ALU_ADD = 1'b0;
    localparam alu_op_t ALU_SUB = 1'b1;

    typedef struct packed {
        alu_op_t op;
    } alu_ctrl_t;
endpackage

/* rtl/ssc_alu.sv */
// shared add and subtract unit with borrow flag for compares
`timescale 1ns / 1ps
module ssc_alu import ssc_pkg::*; #(
    parameter int DW = 40
) (
    input  alu_ctrl_t         ctrl,
    input  logic [DW-1:0]     a,
    input  logic [DW-1:0]     b,
    output logic [DW-1:0]     res,
    output logic              borrow
);
    logic [DW:0] diff;

    assign diff   = {1'b0, a} - {1'b0, b};
    assign borrow = diff[DW];
    assign res    = (ctrl.op == ALU_ADD) ? (a + b) : diff[DW-1:0];
endmodule

/* rtl/ssc_table_ram.sv */
// two-bank half-sum table memory, one write port and two registered read ports
`timescale 1ns / 1ps
module ssc_table_ram #(
    parameter int AW = 16,
    parameter int DW = 36
) (
    input  logic          aclk,
    input  logic          we,
    input  logic          wbank,
    input  logic [AW-1:0] waddr,
    input  logic [DW-1:0] wdata,
    input  logic          rbank,
    input  logic [AW-1:0] raddr_a,
    input  logic [AW-1:0] raddr_b,
    output logic [DW-1:0] rdata_a,
    output logic [DW-1:0] rdata_b
);
    logic [DW-1:0] mem [2**(AW+1)];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[{wbank, waddr}] <= wdata;
        end
        rdata_a <= mem[{rbank, raddr_a}];
        rdata_b <= mem[{rbank, raddr_b}];
    end
endmodule

/* rtl/subset_sum_count_mitm_top.sv */
// subset sum counter top level: value store, sequencer and result register
// values load one per cycle while idle; a request with tlast starts the count
// the table build merges in the first h = n/2 values; each merged entry takes a read, add and write state
// each high-half subset is then counted by two binary searches on table read port a,
// with all arithmetic on the one shared add/subtract unit
// synchronous active-low reset clears the state, item count, running count, output valid and target register
`timescale 1ns / 1ps
module subset_sum_count_mitm_top import ssc_pkg::*; #(
    parameter int MAX_ITEMS  = 32,
    parameter int VALUE_BITS = 30
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_we,
    input  logic [TARGET_W-1:0]   cfg_wdata,   // target_sum
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [S_DATA_W-1:0]   s_tdata,     // item_value
    input  logic                  s_tlast,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [M_DATA_W-1:0]   m_tdata      // match_count
);
    localparam int HALF_MAX = MAX_ITEMS / 2;
    localparam int HW       = MAX_ITEMS - HALF_MAX;
    localparam int AW       = HALF_MAX;
    localparam int IW       = AW + 1;
    localparam int GW       = HW + 1;
    localparam int CW       = $clog2(MAX_ITEMS + 1);
    localparam int VIW      = $clog2(MAX_ITEMS);
    localparam int SUM_W    = VALUE_BITS + CW;
    localparam int DW       = ((SUM_W > TARGET_W) ? SUM_W : TARGET_W) + 1;

    localparam logic [3:0] ST_IDLE   = 4'd0;
    localparam logic [3:0] ST_INIT   = 4'd1;
    localparam logic [3:0] ST_MRD    = 4'd2;
    localparam logic [3:0] ST_MADD   = 4'd3;
    localparam logic [3:0] ST_MWR    = 4'd4;
    localparam logic [3:0] ST_EVAL   = 4'd5;
    localparam logic [3:0] ST_SRD    = 4'd6;
    localparam logic [3:0] ST_SWAIT  = 4'd7;
    localparam logic [3:0] ST_SCMP   = 4'd8;
    localparam logic [3:0] ST_CNT    = 4'd9;
    localparam logic [3:0] ST_ADV    = 4'd10;
    localparam logic [3:0] ST_FLIP   = 4'd11;
    localparam logic [3:0] ST_DONE   = 4'd12;

    logic [3:0]            state_reg, state_next;
    logic [TARGET_W-1:0]   target_reg;
    logic [VALUE_BITS-1:0] store_reg [MAX_ITEMS];
    logic [CW-1:0]         item_cnt_reg, item_cnt_next;
    logic [CW-1:0]         h_reg, h_next, m_reg, m_next, k_reg, k_next;
    logic                  src_reg, src_next;
    logic [IW-1:0]         i_reg, i_next, j_reg, j_next, o_reg, o_next;
    logic [DW-1:0]         shifted_reg, shifted_next;
    logic [SUM_W-1:0]      sum_reg, sum_next;
    logic [DW-1:0]         key_reg, key_next;
    logic [GW-1:0]         g_reg, g_next;
    logic [IW-1:0]         lo_reg, lo_next, hi_reg, hi_next, lb_reg, lb_next;
    logic                  strict_reg, strict_next;
    logic [COUNT_W-1:0]    run_reg, run_next;
    logic [CW-1:0]         flip_reg, flip_next;
    logic                  add_reg, add_next;
    logic                  m_tvalid_reg;
    logic [COUNT_W-1:0]    m_data_reg;

    logic                  in_acc, out_free;
    logic [CW-1:0]         n_val, rd_idx, flip_pos;
    logic                  flip_add;
    logic [VALUE_BITS-1:0] rd_val;
    logic [DW-1:0]         rd_ext;
    logic [IW-1:0]         len, tab_len, mid, diff;
    logic [IW:0]           mid_sum;
    logic [GW-1:0]         g_inc;
    logic [S_DATA_W-1:0]   in_val;

    alu_ctrl_t             alu_ctrl;
    logic [DW-1:0]         alu_a, alu_b, alu_res;
    logic                  alu_borrow;

    logic                  ram_we, ram_wbank;
    logic [AW-1:0]         ram_waddr, ram_ra, ram_rb;
    logic [SUM_W-1:0]      ram_wdata, ram_da, ram_db;
    logic [DW-1:0]         da_ext, db_ext;

    ssc_alu #(.DW(DW)) u_alu (
        .ctrl   (alu_ctrl),
        .a      (alu_a),
        .b      (alu_b),
        .res    (alu_res),
        .borrow (alu_borrow)
    );

    ssc_table_ram #(.AW(AW), .DW(SUM_W)) u_ram (
        .aclk    (aclk),
        .we      (ram_we),
        .wbank   (ram_wbank),
        .waddr   (ram_waddr),
        .wdata   (ram_wdata),
        .rbank   (src_reg),
        .raddr_a (ram_ra),
        .raddr_b (ram_rb),
        .rdata_a (ram_da),
        .rdata_b (ram_db)
    );

    assign s_tready = (state_reg == ST_IDLE);
    assign in_acc   = s_tvalid && s_tready;
    assign out_free = !m_tvalid_reg || m_tready;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {{(M_DATA_W-COUNT_W){1'b0}}, m_data_reg};
    assign in_val   = s_tdata;

    assign n_val    = (item_cnt_reg < CW'(MAX_ITEMS)) ? item_cnt_reg + 1'b1 : item_cnt_reg;
    assign rd_idx   = (state_reg == ST_FLIP) ? h_reg + flip_reg : k_reg;
    assign rd_val   = store_reg[rd_idx[VIW-1:0]];
    assign rd_ext   = {{(DW-VALUE_BITS){1'b0}}, rd_val};
    assign len      = IW'(1) << k_reg;
    assign tab_len  = IW'(1) << h_reg;
    assign mid_sum  = {1'b0, lo_reg} + {1'b0, hi_reg};
    assign mid      = mid_sum[IW:1];
    assign diff     = hi_reg - lb_reg;
    assign g_inc    = g_reg + 1'b1;
    assign da_ext   = {{(DW-SUM_W){1'b0}}, ram_da};
    assign db_ext   = {{(DW-SUM_W){1'b0}}, ram_db};

    // lowest set bit of the next gray step and its new value
    always_comb begin
        flip_pos = '0;
        flip_add = 1'b0;
        for (int p = HW - 1; p >= 0; p--) begin
            if (g_inc[p]) begin
                flip_pos = CW'(p);
                flip_add = !g_inc[p+1];
            end
        end
    end

    always_comb begin
        alu_ctrl.op = ALU_SUB;
        alu_a       = '0;
        alu_b       = '0;
        unique case (state_reg)
            ST_MADD: begin
                alu_ctrl.op = ALU_ADD;
                alu_a       = db_ext;
                alu_b       = rd_ext;
            end
            ST_MWR: begin
                alu_a = shifted_reg;
                alu_b = da_ext;
            end
            ST_EVAL: begin
                alu_a = {{(DW-TARGET_W){1'b0}}, target_reg};
                alu_b = {{(DW-SUM_W){1'b0}}, sum_reg};
            end
            ST_SCMP: begin
                alu_a = strict_reg ? key_reg : da_ext;
                alu_b = strict_reg ? da_ext : key_reg;
            end
            ST_CNT: begin
                alu_ctrl.op = ALU_ADD;
                alu_a       = {{(DW-COUNT_W){1'b0}}, run_reg};
                alu_b       = {{(DW-IW){1'b0}}, diff};
            end
            ST_FLIP: begin
                alu_ctrl.op = add_reg ? ALU_ADD : ALU_SUB;
                alu_a       = {{(DW-SUM_W){1'b0}}, sum_reg};
                alu_b       = rd_ext;
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        state_next    = state_reg;
        item_cnt_next = item_cnt_reg;
        h_next        = h_reg;
        m_next        = m_reg;
        k_next        = k_reg;
        src_next      = src_reg;
        i_next        = i_reg;
        j_next        = j_reg;
        o_next        = o_reg;
        shifted_next  = shifted_reg;
        sum_next      = sum_reg;
        key_next      = key_reg;
        g_next        = g_reg;
        lo_next       = lo_reg;
        hi_next       = hi_reg;
        lb_next       = lb_reg;
        strict_next   = strict_reg;
        run_next      = run_reg;
        flip_next     = flip_reg;
        add_next      = add_reg;
        ram_we        = 1'b0;
        ram_wbank     = !src_reg;
        ram_waddr     = o_reg[AW-1:0];
        ram_wdata     = '0;
        ram_ra        = i_reg[AW-1:0];
        ram_rb        = j_reg[AW-1:0];
        unique case (state_reg)
            ST_IDLE: begin
                if (in_acc) begin
                    item_cnt_next = n_val;
                    if (s_tlast) begin
                        h_next     = n_val >> 1;
                        m_next     = n_val - (n_val >> 1);
                        state_next = ST_INIT;
                    end
                end
            end
            ST_INIT: begin
                ram_we    = 1'b1;
                ram_wbank = 1'b0;
                ram_waddr = '0;
                src_next  = 1'b0;
                k_next    = '0;
                i_next    = '0;
                j_next    = '0;
                o_next    = '0;
                sum_next  = '0;
                g_next    = '0;
                run_next  = '0;
                state_next = (h_reg == '0) ? ST_EVAL : ST_MRD;
            end
            ST_MRD: begin
                state_next = ST_MADD;
            end
            ST_MADD: begin
                shifted_next = alu_res;
                state_next   = ST_MWR;
            end
            ST_MWR: begin
                ram_we = 1'b1;
                if ((j_reg >= len) || ((i_reg < len) && !alu_borrow)) begin
                    ram_wdata = ram_da;
                    i_next    = i_reg + 1'b1;
                end else begin
                    ram_wdata = shifted_reg[SUM_W-1:0];
                    j_next    = j_reg + 1'b1;
                end
                o_next     = o_reg + 1'b1;
                state_next = ST_MRD;
                if (o_reg + 1'b1 == (len << 1)) begin
                    src_next = !src_reg;
                    k_next   = k_reg + 1'b1;
                    i_next   = '0;
                    j_next   = '0;
                    o_next   = '0;
                    if (k_reg + 1'b1 == h_reg) begin
                        state_next = ST_EVAL;
                    end
                end
            end
            ST_EVAL: begin
                key_next    = alu_res;
                lo_next     = '0;
                hi_next     = tab_len;
                strict_next = 1'b0;
                state_next  = alu_borrow ? ST_ADV : ST_SRD;
            end
            ST_SRD: begin
                ram_ra = mid[AW-1:0];
                if (lo_reg == hi_reg) begin
                    if (strict_reg) begin
                        state_next = ST_CNT;
                    end else begin
                        lb_next     = lo_reg;
                        lo_next     = '0;
                        hi_next     = tab_len;
                        strict_next = 1'b1;
                    end
                end else begin
                    state_next = ST_SWAIT;
                end
            end
            ST_SWAIT: begin
                ram_ra     = mid[AW-1:0];
                state_next = ST_SCMP;
            end
            ST_SCMP: begin
                // strict: go right on entry <= key, else on entry < key
                if (strict_reg ? !alu_borrow : alu_borrow) begin
                    lo_next = mid + 1'b1;
                end else begin
                    hi_next = mid;
                end
                state_next = ST_SRD;
            end
            ST_CNT: begin
                if (alu_res[DW-1:COUNT_W] != '0) begin
                    run_next = '1;
                end else begin
                    run_next = alu_res[COUNT_W-1:0];
                end
                state_next = ST_ADV;
            end
            ST_ADV: begin
                if (g_inc == (GW'(1) << m_reg)) begin
                    state_next = ST_DONE;
                end else begin
                    flip_next  = flip_pos;
                    add_next   = flip_add;
                    g_next     = g_inc;
                    state_next = ST_FLIP;
                end
            end
            ST_FLIP: begin
                sum_next   = alu_res[SUM_W-1:0];
                state_next = ST_EVAL;
            end
            ST_DONE: begin
                if (out_free) begin
                    item_cnt_next = '0;
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            item_cnt_reg <= '0;
            target_reg   <= '0;
            run_reg      <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            item_cnt_reg <= item_cnt_next;
            run_reg      <= run_next;
            if (cfg_we) begin
                target_reg <= cfg_wdata;
            end
            if (state_reg == ST_DONE && out_free) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        h_reg       <= h_next;
        m_reg       <= m_next;
        k_reg       <= k_next;
        src_reg     <= src_next;
        i_reg       <= i_next;
        j_reg       <= j_next;
        o_reg       <= o_next;
        shifted_reg <= shifted_next;
        sum_reg     <= sum_next;
        key_reg     <= key_next;
        g_reg       <= g_next;
        lo_reg      <= lo_next;
        hi_reg      <= hi_next;
        lb_reg      <= lb_next;
        strict_reg  <= strict_next;
        flip_reg    <= flip_next;
        add_reg     <= add_next;
        if (state_reg == ST_DONE && out_free) begin
            m_data_reg <= run_reg;
        end
        if (in_acc && item_cnt_reg < CW'(MAX_ITEMS)) begin
            store_reg[item_cnt_reg[VIW-1:0]] <= in_val[VALUE_BITS-1:0];
        end
    end

    a_cnt_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        item_cnt_reg <= CW'(MAX_ITEMS))
        else $error("item count beyond store depth");

    a_search_order: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SRD) |-> (lo_reg <= hi_reg))
        else $error("binary search bounds crossed");

    a_result_out: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DONE && out_free) |=>
            (m_tvalid_reg && state_reg == ST_IDLE && item_cnt_reg == '0))
        else $error("result not issued on completion");
endmodule

/* tb/tb_top.sv */
// testbench for the subset sum counter: directed and random sets, scored against its own count
`timescale 1ns / 1ps
module tb_top;
    import ssc_pkg::*;

    localparam int STORE_DEPTH = 32;
    localparam longint unsigned VALUE_MAX = (64'd1 << ITEM_W) - 1;
    localparam longint unsigned TARGET_MAX = (64'd1 << TARGET_W) - 1;
    localparam longint unsigned COUNT_MAX = (64'd1 << COUNT_W) - 1;

    logic                aclk = 1'b0;
    logic                aresetn = 1'b0;
    logic                cfg_we = 1'b0;
    logic [TARGET_W-1:0] cfg_wdata = '0;
    logic                s_tvalid = 1'b0;
    logic                s_tready;
    logic [S_DATA_W-1:0] s_tdata = '0;
    logic                s_tlast = 1'b0;
    logic                m_tvalid;
    logic                m_tready = 1'b0;
    logic [M_DATA_W-1:0] m_tdata;

    longint unsigned target_sum = 0;
    longint unsigned set_values[STORE_DEPTH];
    int              set_len = 0;
    longint unsigned pending_counts[$];
    int              mismatches = 0;
    int              sender_idle_pct = 0;
    int              receiver_idle_pct = 0;
    int              hold_req = 0;
    int              hold_len = 0;
    int              hold_seen = 0;
    int              hold_left = 0;

    subset_sum_count_mitm_top u_dut (
        .aclk(aclk), .aresetn(aresetn), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
    );

    always #4 aclk = ~aclk;

    // meet in the middle count over the values held in this set
    function automatic longint unsigned count_matches();
        longint unsigned half_sums[];
        longint unsigned merged[];
        longint unsigned acc;
        longint unsigned key;
        int h, i, j, o, lo, hi, mid, first, past;
        longint unsigned total;
        h = set_len / 2;
        half_sums = new[1];
        half_sums[0] = 0;
        for (int k = 0; k < h; k++) begin
            merged = new[half_sums.size() * 2];
            i = 0; j = 0; o = 0;
            while (i < half_sums.size() || j < half_sums.size()) begin
                if (j >= half_sums.size() || (i < half_sums.size() &&
                        half_sums[i] <= half_sums[j] + set_values[k])) begin
                    merged[o] = half_sums[i]; i++;
                end else begin
                    merged[o] = half_sums[j] + set_values[k]; j++;
                end
                o++;
            end
            half_sums = merged;
        end
        total = 0;
        for (longint m = 0; m < (longint'(1) << (set_len - h)); m++) begin
            acc = 0;
            for (int b = 0; b < set_len - h; b++)
                if (m[b]) acc += set_values[h + b];
            if (acc <= target_sum) begin
                key = target_sum - acc;
                lo = 0; hi = half_sums.size();
                while (lo < hi) begin
                    mid = (lo + hi) / 2;
                    if (half_sums[mid] < key) lo = mid + 1; else hi = mid;
                end
                first = lo;
                lo = 0; hi = half_sums.size();
                while (lo < hi) begin
                    mid = (lo + hi) / 2;
                    if (half_sums[mid] <= key) lo = mid + 1; else hi = mid;
                end
                past = lo;
                total += past - first;
            end
        end
        return (total > COUNT_MAX) ? COUNT_MAX : total;
    endfunction

    task automatic send_value(input longint unsigned value, input bit last);
        while (sender_idle_pct > 0 && $urandom_range(99) < sender_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= S_DATA_W'(value & VALUE_MAX);
        s_tlast  <= last;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        if (set_len < STORE_DEPTH) begin
            set_values[set_len] = value & VALUE_MAX;
            set_len++;
        end
        if (last) begin
            pending_counts = {pending_counts, count_matches()};
            set_len = 0;
        end
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending_counts.size() != 0) @(posedge aclk);
        repeat (40) @(posedge aclk);
    endtask

    task automatic write_target(input longint unsigned value);
        drain();
        cfg_we    <= 1'b1;
        cfg_wdata <= TARGET_W'(value);
        @(posedge aclk);
        cfg_we    <= 1'b0;
        target_sum = value & TARGET_MAX;
    endtask

    task automatic send_set(input int n, input longint unsigned vmax);
        for (int k = 0; k < n; k++)
            send_value($urandom_range(1, 64'(vmax) > 32'hffffffff ? 32'hffffffff : vmax),
                       k == n - 1);
    endtask

    task automatic test_directed();
        send_value(5, 1'b1);
        send_value(0, 1'b0);
        send_value(0, 1'b1);
        write_target(10);
        send_value(1, 1'b0); send_value(2, 1'b0); send_value(3, 1'b0);
        send_value(4, 1'b0); send_value(10, 1'b0); send_value(0, 1'b1);
        send_value(5, 1'b0); send_value(5, 1'b0); send_value(5, 1'b0); send_value(5, 1'b1);
        write_target(TARGET_MAX);
        send_value(VALUE_MAX, 1'b0); send_value(VALUE_MAX, 1'b0); send_value(1, 1'b1);
        write_target(2 * VALUE_MAX + 1);
        send_value(VALUE_MAX, 1'b0); send_value(VALUE_MAX, 1'b0);
        send_value(1, 1'b0); send_value(VALUE_MAX, 1'b1);
    endtask

    // more values than the store holds, last flag on a dropped value
    task automatic test_store_full();
        write_target(3);
        for (int k = 0; k < STORE_DEPTH + 3; k++)
            send_value((k % 5 == 0) ? 1 : VALUE_MAX - k, k == STORE_DEPTH + 2);
        drain();
    endtask

    task automatic test_random(input int snd_pct, input int rcv_pct, input int n_items);
        int sent;
        int n;
        sender_idle_pct = snd_pct;
        receiver_idle_pct = rcv_pct;
        sent = 0;
        while (sent < n_items) begin
            if ($urandom_range(3) == 0) begin
                case ($urandom_range(3))
                    0: write_target($urandom_range(0, 40));
                    1: write_target({$urandom, $urandom} & TARGET_MAX);
                    2: write_target(0);
                    default: write_target($urandom_range(0, 200));
                endcase
            end
            n = ($urandom_range(19) == 0) ? $urandom_range(11, 16) : $urandom_range(1, 10);
            if ($urandom_range(3) == 0)
                send_set(n, VALUE_MAX);
            else
                send_set(n, $urandom_range(1, 30));
            sent += n;
        end
        drain();
    endtask

    task automatic test_backpressure();
        sender_idle_pct = 0;
        receiver_idle_pct = 0;
        write_target(12);
        hold_len = 3000;
        hold_req++;
        for (int k = 0; k < 6; k++) send_set($urandom_range(2, 8), 8);
        drain();
    endtask

    always @(posedge aclk) begin
        if (hold_req != hold_seen) begin
            hold_seen <= hold_req;
            hold_left <= hold_len;
            m_tready  <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            m_tready  <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= receiver_idle_pct);
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_counts.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result: match_count %0d", m_tdata[COUNT_W-1:0]);
            end else begin
                if (m_tdata[COUNT_W-1:0] !== COUNT_W'(pending_counts[0])) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("match_count mismatch: expected %0d actual %0d",
                                 pending_counts[0], m_tdata[COUNT_W-1:0]);
                end
                void'(pending_counts.pop_front());
            end
        end
    end

    initial begin
        repeat (30_000_000) @(posedge aclk);
        $display("FAILURE");
        $finish;
    end

    initial begin
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed();
        test_store_full();
        test_random(28, 77, 540);
        test_random(77, 28, 540);
        test_random(0, 0, 540);
        test_backpressure();
        drain();
        if (mismatches == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end
endmodule
